>>> rtl/drm_pkg.sv
// shared types and constants of the debounced rpm meter
package drm_pkg;

  // field and register widths
  localparam int unsigned RpmW   = 20;
  localparam int unsigned PulseW = 16;
  localparam int unsigned DebW   = 16;
  localparam int unsigned WinW   = 24;
  localparam int unsigned PprW   = 8;

  // divider widths: pulses times microseconds per minute, ppr times window
  localparam int unsigned NumW    = 46;
  localparam int unsigned DenW    = 32;
  localparam int unsigned DivCntW = $clog2(NumW + 1);

  // window result queue
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // output stream payload: rpm_now, rpm_mean, window_pulses
  localparam int unsigned OutW = 2 * RpmW + PulseW;

  localparam logic [29:0]       MicrosPerMinQ4 = 30'd960000000;
  localparam logic [RpmW-1:0]   RpmMax         = '1;
  localparam logic [PulseW-1:0] PulseMax       = '1;
  localparam logic [DebW-1:0]   DebMax         = '1;

  // register indexes
  localparam logic [1:0] RegDebounce = 2'd0;
  localparam logic [1:0] RegWindow   = 2'd1;
  localparam logic [1:0] RegPpr      = 2'd2;

  localparam logic [DebW-1:0] DebounceReset = 16'd2000;
  localparam logic [WinW-1:0] WindowReset   = 24'd1000000;
  localparam logic [PprW-1:0] PprReset      = 8'd4;

  typedef struct packed {
    logic [DebW-1:0] debounce;
    logic [WinW-1:0] window;
    logic [PprW-1:0] ppr;
  } cfg_t;

  // front to queue
  typedef struct packed {
    logic              push;
    logic [PulseW-1:0] pulses;
  } q_wr_t;

  // queue to back
  typedef struct packed {
    logic              valid;
    logic [PulseW-1:0] pulses;
  } q_rd_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quot;
  } div_rsp_t;

endpackage

>>> rtl/drm_front.sv
// tick front end: debounce, pulse tally and window timing
module drm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  drm_pkg::cfg_t                 cfg_i,
  input  logic                          tick_valid_i,
  input  logic                          edge_seen_i,
  output logic                          tick_ready_o,
  input  logic                          q_full_i,
  output drm_pkg::q_wr_t                q_wr_o
);
  import drm_pkg::*;

  logic [DebW-1:0]   since_q, since_d, since_inc;
  logic [WinW-1:0]   elapsed_q, elapsed_d, elapsed_inc, win_eff;
  logic [PulseW-1:0] tally_q, tally_d, tally_inc;
  logic              counted, win_end, accept;

  // next-tick values, independent of the tick payload except the edge flag
  always_comb begin
    win_eff     = (cfg_i.window == '0) ? WinW'(1) : cfg_i.window;
    since_inc   = (since_q == DebMax) ? since_q : since_q + DebW'(1);
    counted     = edge_seen_i && (since_inc > cfg_i.debounce);
    tally_inc   = (counted && (tally_q != PulseMax)) ? tally_q + PulseW'(1) : tally_q;
    elapsed_inc = elapsed_q + WinW'(1);
    win_end     = (elapsed_inc >= win_eff);
  end

  // a tick that closes a window needs a free queue slot
  assign tick_ready_o = !q_full_i || !win_end;
  assign accept       = tick_valid_i && tick_ready_o;

  assign q_wr_o.push   = accept && win_end;
  assign q_wr_o.pulses = tally_inc;

  always_comb begin
    since_d   = since_q;
    elapsed_d = elapsed_q;
    tally_d   = tally_q;
    if (accept) begin
      since_d = counted ? '0 : since_inc;
      if (win_end) begin
        elapsed_d = '0;
        tally_d   = '0;
      end else begin
        elapsed_d = elapsed_inc;
        tally_d   = tally_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_q   <= '0;
      elapsed_q <= '0;
      tally_q   <= '0;
    end else begin
      since_q   <= since_d;
      elapsed_q <= elapsed_d;
      tally_q   <= tally_d;
    end
  end

endmodule

>>> rtl/drm_queue.sv
// short queue of finished window pulse counts
module drm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  drm_pkg::q_wr_t  q_wr_i,
  output logic            q_full_o,
  input  logic            q_pop_i,
  output drm_pkg::q_rd_t  q_rd_o
);
  import drm_pkg::*;

  logic [PulseW-1:0] mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign q_full_o      = (cnt_q == QCntW'(QDepth));
  assign q_rd_o.valid  = (cnt_q != '0);
  assign q_rd_o.pulses = mem_q[rd_ptr_q];

  assign do_push = q_wr_i.push && !q_full_o;
  assign do_pop  = q_pop_i && q_rd_o.valid;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= q_wr_i.pulses;
    end
  end

endmodule

>>> rtl/drm_div.sv
// restoring divider, one quotient bit per cycle while busy
module drm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  drm_pkg::div_req_t req_i,
  output drm_pkg::div_rsp_t rsp_o
);
  import drm_pkg::*;

  logic [NumW-1:0]    num_q, num_d;
  logic [DenW-1:0]    rem_q, rem_d, den_q, den_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DenW:0]      trial, diff;
  logic               fits;

  // one shift-subtract step; quotient bits shift in at the bottom of num
  always_comb begin
    trial = {rem_q, num_q[NumW-1]};
    fits  = (trial >= {1'b0, den_q});
    diff  = trial - {1'b0, den_q};
  end

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      num_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = DivCntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[DenW-1:0] : trial[DenW-1:0];
      num_d = {num_q[NumW-2:0], fits};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

>>> rtl/drm_back.sv
// back end: window rpm, history ring, mean and output register
module drm_back #(
  parameter int unsigned AVG_DEPTH = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  drm_pkg::cfg_t              cfg_i,
  input  drm_pkg::q_rd_t             q_rd_i,
  output logic                       q_pop_o,
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic [drm_pkg::OutW-1:0]   m_tdata_o
);
  import drm_pkg::*;

  localparam int unsigned SlotW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int unsigned SumW  = RpmW + $clog2(AVG_DEPTH);

  // mean by reciprocal multiplication: floor(sum / AVG_DEPTH) for any sum below 2**SumW
  localparam int unsigned MeanSh   = SumW + $clog2(AVG_DEPTH);
  localparam int unsigned MeanMulW = SumW + 1;
  localparam int unsigned ProdW    = SumW + MeanMulW;
  localparam logic [MeanMulW-1:0] MeanMul =
    MeanMulW'(((64'd1 << MeanSh) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_DIVR = 6'b000100,
    S_HIST = 6'b001000,
    S_MEAN = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [PulseW-1:0] pulses_q;
  logic [RpmW-1:0]   rpm_q;
  logic [RpmW-1:0]   hist_q [AVG_DEPTH];
  logic [SlotW-1:0]  slot_q, slot_next;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [ProdW-1:0]  mean_prod;
  logic [OutW-1:0]   out_q;
  logic              out_valid_q;
  logic [PprW-1:0]   ppr_eff;
  logic [WinW-1:0]   win_eff;
  logic [NumW-1:0]   num_mul;
  logic [DenW-1:0]   den_mul;
  logic [RpmW-1:0]   rpm_sat;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  drm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // operands of the rpm division
  always_comb begin
    ppr_eff = (cfg_i.ppr == '0) ? PprW'(1) : cfg_i.ppr;
    win_eff = (cfg_i.window == '0) ? WinW'(1) : cfg_i.window;
    num_mul = NumW'(pulses_q) * NumW'(MicrosPerMinQ4);
    den_mul = DenW'(ppr_eff) * DenW'(win_eff);
  end

  // saturate the rpm quotient
  assign rpm_sat = (div_rsp.quot > NumW'(RpmMax)) ? RpmMax : div_rsp.quot[RpmW-1:0];

  // running sum of the ring, replacing the oldest entry
  assign sum_d     = sum_q - SumW'(hist_q[slot_q]) + SumW'(rpm_q);
  assign slot_next = (slot_q == SlotW'(AVG_DEPTH - 1)) ? '0 : slot_q + SlotW'(1);

  // mean of the registered ring sum
  assign mean_prod = ProdW'(sum_q) * ProdW'(MeanMul);

  // divider request for the rpm
  always_comb begin
    div_req.start = (state_q == S_MUL);
    div_req.num   = num_mul;
    div_req.den   = den_mul;
  end

  assign q_pop_o = (state_q == S_IDLE) && q_rd_i.valid;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (q_rd_i.valid) state_d = S_MUL;
      S_MUL:  state_d = S_DIVR;
      S_DIVR: if (div_rsp.done) state_d = S_HIST;
      S_HIST: state_d = S_MEAN;
      S_MEAN: state_d = S_OUT;
      S_OUT:  if (m_tready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state, history ring and sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      slot_q      <= '0;
      sum_q       <= '0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_MEAN) begin
        out_valid_q <= 1'b1;
      end else if ((state_q == S_OUT) && m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_HIST) begin
        hist_q[slot_q] <= rpm_q;
        slot_q         <= slot_next;
        sum_q          <= sum_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      pulses_q <= q_rd_i.pulses;
    end
    if ((state_q == S_DIVR) && div_rsp.done) begin
      rpm_q <= rpm_sat;
    end
    if (state_q == S_MEAN) begin
      out_q <= {pulses_q, mean_prod[MeanSh +: RpmW], rpm_q};
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_q;

endmodule

>>> rtl/debounced_rpm_meter_moving_average.sv
// top level of the debounced rpm meter with moving average
// One request on the input stream is one microsecond tick; bit 0 of tdata says
// whether a falling hall edge was seen. An edge counts only when more than
// debounce_us ticks have passed since the last counted one. At the last tick of
// each window_us-tick window one result leaves on the output stream: the
// window rpm (4 fraction bits, saturated), the floor mean of the last AVG_DEPTH
// window rpm values and the pulse count. Ticks are taken at one per clock; the
// front end stalls a tick only when it closes a window while the four-entry
// result queue is full. The back end takes one window result at a time through
// the 46-step divider for the rpm (the mean is a reciprocal multiplication) and
// then waits for the output to be taken. The rpm history is cleared at reset in
// flip-flops, so no start-up pass is needed.
// Registers: debounce_us at 0x0, window_us at 0x4, pulses_per_rev at 0x8; write
// them only while idle.
module debounced_rpm_meter_moving_average #(
  parameter int unsigned AVG_DEPTH = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input ticks
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [7:0]                s_axis_tdata_i,  // [0] edge_seen
  // window results
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [drm_pkg::OutW-1:0]  m_axis_tdata_o,  // [19:0] rpm_now, [39:20] rpm_mean,
                                                     // [55:40] window_pulses
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import drm_pkg::*;

  cfg_t  cfg_q;
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full, q_pop, cfg_wr;

  // register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce <= DebounceReset;
      cfg_q.window   <= WindowReset;
      cfg_q.ppr      <= PprReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegDebounce: cfg_q.debounce <= pwdata[DebW-1:0];
        RegWindow:   cfg_q.window   <= pwdata[WinW-1:0];
        RegPpr:      cfg_q.ppr      <= pwdata[PprW-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[3:2])
      RegDebounce: prdata = 32'(cfg_q.debounce);
      RegWindow:   prdata = 32'(cfg_q.window);
      RegPpr:      prdata = 32'(cfg_q.ppr);
      default:     prdata = '0;
    endcase
  end

  drm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .tick_valid_i (s_axis_tvalid_i),
    .edge_seen_i  (s_axis_tdata_i[0]),
    .tick_ready_o (s_axis_tready_o),
    .q_full_i     (q_full),
    .q_wr_o       (q_wr)
  );

  drm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_wr_i   (q_wr),
    .q_full_o (q_full),
    .q_pop_i  (q_pop),
    .q_rd_o   (q_rd)
  );

  drm_back #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_rd_i     (q_rd),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o)
  );

endmodule

>>> rtl/drm_checker.sv
// port-level checks of the rpm meter and their binding
module drm_checker #(
  parameter int unsigned AVG_DEPTH = 5
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     m_tvalid_i,
  input logic                     m_tready_i,
  input logic [drm_pkg::OutW-1:0] m_tdata_i,
  input logic                     psel_i,
  input logic                     penable_i,
  input logic                     pready_i
);
  import drm_pkg::*;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("output result changed while stalled");

  // a window without pulses reads zero rpm
  a_zero_rpm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tdata_i[OutW-1:2*RpmW] == '0) |-> (m_tdata_i[RpmW-1:0] == '0))
    else $error("nonzero rpm with no pulses");

  // with a single history entry the mean is the window rpm
  a_mean_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (AVG_DEPTH == 1) |-> (m_tdata_i[2*RpmW-1:RpmW] == m_tdata_i[RpmW-1:0]))
    else $error("mean differs from rpm with one history entry");

  // register access completes in its access cycle
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && penable_i |-> pready_i)
    else $error("register access not ready");

endmodule

bind debounced_rpm_meter_moving_average drm_checker #(
  .AVG_DEPTH (AVG_DEPTH)
) u_drm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .psel_i     (psel),
  .penable_i  (penable),
  .pready_i   (pready)
);

>>> verif/tb_debounced_rpm_meter_moving_average.sv
// testbench of the rpm meter: ticks in, window results checked against a predictor
`timescale 1ns / 1ps

module tb_debounced_rpm_meter_moving_average;
  import drm_pkg::*;

  localparam int unsigned AVG_DEPTH    = 5;
  localparam int unsigned RANDOM_TICKS = 1580;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned END_CYCLES   = 300;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned LIMIT        = 2000000;
  localparam int unsigned PLAN_ROWS    = 32;

  typedef struct packed {
    logic [RpmW-1:0]   rpm_now;
    logic [RpmW-1:0]   rpm_mean;
    logic [PulseW-1:0] pulses;
  } window_result_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_TICK} row_kind_e;

  // one directed step: a register write or a tick, optionally with a typed result
  typedef struct packed {
    row_kind_e      kind;
    logic [1:0]     reg_idx;
    logic [31:0]    value;
    logic           edge_bit;
    logic           typed;
    window_result_t res;
  } plan_row_t;

  logic              clk_i;
  logic              rst_n         = 1'b0;
  logic              tick_valid    = 1'b0;
  logic [7:0]        tick_data     = '0;
  logic              result_ready  = 1'b0;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [3:0]        paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic              tick_ready;
  logic              result_valid;
  logic [OutW-1:0]   result_data;
  logic [31:0]       prdata;
  logic              pready;

  // predictor copy of registers and state
  logic [DebW-1:0]   deb_cfg;
  logic [WinW-1:0]   win_cfg;
  logic [PprW-1:0]   ppr_cfg;
  logic [DebW-1:0]   since_edge;
  logic [WinW-1:0]   ticks_in_window;
  logic [PulseW-1:0] tally;
  logic [RpmW-1:0]   rpm_ring [AVG_DEPTH];
  int unsigned       ring_slot;

  window_result_t    windows_due [$];
  int unsigned       fail_count   = 0;
  int unsigned       cycle_count  = 0;
  bit                src_gaps     = 1'b1;
  bit                snk_gaps     = 1'b1;
  bit                hold_req     = 1'b0;
  plan_row_t         plan [PLAN_ROWS];

  debounced_rpm_meter_moving_average #(
    .AVG_DEPTH(AVG_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(tick_valid),
    .s_axis_tready_o(tick_ready),
    .s_axis_tdata_i (tick_data),
    .m_axis_tvalid_o(result_valid),
    .m_axis_tready_i(result_ready),
    .m_axis_tdata_o (result_data),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("** debounced_rpm_meter_moving_average: FAILED **");
      $finish;
    end
  end

  function automatic logic [31:0] field_mask(input logic [1:0] idx);
    case (idx)
      RegDebounce: return 32'h0000_FFFF;
      RegWindow:   return 32'h00FF_FFFF;
      default:     return 32'h0000_00FF;
    endcase
  endfunction

  // one microsecond tick of the meter
  task automatic advance_meter(input logic edge_bit, output bit got,
                               output window_result_t res);
    logic [WinW-1:0]   win_len;
    longint unsigned   num;
    longint unsigned   den;
    longint unsigned   quot;
    int unsigned       sum;
    int                i;
    win_len = (win_cfg == '0) ? WinW'(1) : win_cfg;
    got = 1'b0;
    res = '0;
    if (since_edge != DebMax) since_edge++;
    if (edge_bit && since_edge > deb_cfg) begin
      if (tally != PulseMax) tally++;
      since_edge = '0;
    end
    ticks_in_window++;
    if (ticks_in_window >= win_len) begin
      num  = 64'(tally) * 64'(MicrosPerMinQ4);
      den  = 64'((ppr_cfg == '0) ? PprW'(1) : ppr_cfg) * 64'(win_len);
      quot = num / den;
      res.rpm_now = (quot > 64'(RpmMax)) ? RpmMax : quot[RpmW-1:0];
      rpm_ring[ring_slot] = res.rpm_now;
      ring_slot = (ring_slot + 1) % AVG_DEPTH;
      sum = 0;
      for (i = 0; i < AVG_DEPTH; i++) sum += rpm_ring[i];
      res.rpm_mean = RpmW'(sum / AVG_DEPTH);
      res.pulses = tally;
      ticks_in_window = '0;
      tally = '0;
      got = 1'b1;
    end
  endtask

  // offer one tick request after a random gap, predict on acceptance
  task automatic send_tick(input logic edge_bit, input bit typed,
                           input window_result_t typed_res);
    int unsigned    gap;
    bit             got;
    window_result_t res;
    gap = src_gaps ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_valid <= 1'b1;
    tick_data  <= {7'd0, edge_bit};
    @(posedge clk_i);
    while (!tick_ready) @(posedge clk_i);
    advance_meter(edge_bit, got, res);
    if (got) windows_due.push_back(typed ? typed_res : res);
  endtask

  // drop the tick stream and let the block drain
  task automatic wait_for_idle();
    @(negedge clk_i);
    tick_valid <= 1'b0;
    while (windows_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // apb write, then read back the field bits
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    mask = field_mask(idx);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      RegDebounce: deb_cfg = value[DebW-1:0];
      RegWindow:   win_cfg = value[WinW-1:0];
      default:     ppr_cfg = value[PprW-1:0];
    endcase
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if ((prdata & mask) != (value & mask)) begin
      $display("%0t: register %0d read expected %0h, got %0h",
               $time, idx, value & mask, prdata & mask);
      fail_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side: random stalls, one long hold-off on request, field checks
  initial begin
    int unsigned    hold_left;
    int unsigned    stall_left;
    window_result_t got_res;
    window_result_t want;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
      @(posedge clk_i);
      if (result_valid && result_ready) begin
        got_res.rpm_now  = result_data[RpmW-1:0];
        got_res.rpm_mean = result_data[2*RpmW-1:RpmW];
        got_res.pulses   = result_data[OutW-1:2*RpmW];
        if (windows_due.size() == 0) begin
          $display("%0t: result with none expected, got %0h", $time, result_data);
          fail_count++;
        end else begin
          want = windows_due.pop_front();
          if (got_res.rpm_now != want.rpm_now) begin
            $display("%0t: rpm_now expected %0d, got %0d",
                     $time, want.rpm_now, got_res.rpm_now);
            fail_count++;
          end
          if (got_res.rpm_mean != want.rpm_mean) begin
            $display("%0t: rpm_mean expected %0d, got %0d",
                     $time, want.rpm_mean, got_res.rpm_mean);
            fail_count++;
          end
          if (got_res.pulses != want.pulses) begin
            $display("%0t: window_pulses expected %0d, got %0d",
                     $time, want.pulses, got_res.pulses);
            fail_count++;
          end
        end
        stall_left = snk_gaps ? $urandom_range(0, 5) : 0;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned random_ticks;
    int unsigned n_ticks;
    int unsigned k;
    int unsigned density;
    int unsigned period;
    int unsigned countdown;
    bit          periodic;
    logic [31:0] value;
    logic        edge_bit;

    deb_cfg         = DebounceReset;
    win_cfg         = WindowReset;
    ppr_cfg         = PprReset;
    since_edge      = '0;
    ticks_in_window = '0;
    tally           = '0;
    ring_slot       = 0;
    foreach (rpm_ring[i]) rpm_ring[i] = '0;

    // directed plan, opening with zero window and zero ppr so that every tick is a result
    plan = '{
      '{ROW_WRITE, RegDebounce, 32'd0, 1'b0, 1'b0, '0},
      '{ROW_WRITE, RegWindow, 32'd0, 1'b0, 1'b0, '0},
      '{ROW_WRITE, RegPpr, 32'd0, 1'b0, 1'b0, '0},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b1, 1'b1, '{RpmMax, 20'd209715, 16'd1}},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b0, 1'b1, '{20'd0, 20'd209715, 16'd0}},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b1, 1'b1, '{RpmMax, 20'd419430, 16'd1}},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b1, 1'b1, '{RpmMax, 20'd629145, 16'd1}},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b1, 1'b1, '{RpmMax, 20'd838860, 16'd1}},
      // history ring wraps here
      '{ROW_TICK, RegDebounce, 32'd0, 1'b0, 1'b1, '{20'd0, 20'd629145, 16'd0}},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b1, 1'b1, '{RpmMax, 20'd838860, 16'd1}},
      // largest debounce blocks the edge
      '{ROW_WRITE, RegDebounce, 32'h0000_FFFF, 1'b0, 1'b0, '0},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b1, 1'b1, '{20'd0, 20'd629145, 16'd0}},
      // upper bus bits ignored, largest ppr
      '{ROW_WRITE, RegDebounce, 32'hABCD_0003, 1'b0, 1'b0, '0},
      '{ROW_WRITE, RegWindow, 32'hFF00_0003, 1'b0, 1'b0, '0},
      '{ROW_WRITE, RegPpr, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b1, 1'b0, '0},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b0, 1'b0, '0},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b1, 1'b0, '0},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b1, 1'b0, '0},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b1, 1'b0, '0},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b1, 1'b0, '0},
      // largest window, then shortened below the elapsed ticks
      '{ROW_WRITE, RegWindow, 32'h00FF_FFFF, 1'b0, 1'b0, '0},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b1, 1'b0, '0},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b0, 1'b0, '0},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b0, 1'b0, '0},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b1, 1'b0, '0},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b1, 1'b0, '0},
      '{ROW_WRITE, RegWindow, 32'd2, 1'b0, 1'b0, '0},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b0, 1'b0, '0},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b1, 1'b0, '0},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b0, 1'b0, '0},
      '{ROW_TICK, RegDebounce, 32'd0, 1'b1, 1'b0, '0}
    };

    // reset
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) begin
        wait_for_idle();
        write_reg(plan[r].reg_idx, plan[r].value);
      end else begin
        send_tick(plan[r].edge_bit, plan[r].typed, plan[r].res);
      end
    end

    // debounce near its maximum: closely spaced edges never count
    src_gaps = 1'b0;
    wait_for_idle();
    write_reg(RegDebounce, 32'h0000_FFFE);
    write_reg(RegWindow, 32'd2);
    write_reg(RegPpr, 32'd3);
    for (k = 0; k < 6; k++) send_tick(1'b1, 1'b0, '0);

    // receiver holds off while every tick closes a window
    wait_for_idle();
    write_reg(RegWindow, 32'd0);
    write_reg(RegDebounce, 32'd1);
    write_reg(RegPpr, 32'd7);
    hold_req = 1'b1;
    for (k = 0; k < 40; k++) send_tick($urandom_range(0, 1), 1'b0, '0);

    // random phases
    random_ticks = 0;
    while (random_ticks < RANDOM_TICKS) begin
      wait_for_idle();
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 6))
          0:       value = {$urandom} & 32'hFF00_0000 | ($urandom & 32'h00FF_FFFF);
          1:       value = $urandom_range(41, 400);
          default: value = {$urandom} & 32'hFF00_0000 | 32'($urandom_range(0, 40));
        endcase
        write_reg(RegWindow, value);
      end
      if ($urandom_range(0, 9) < 6) begin
        if ($urandom_range(0, 4) == 0) value = $urandom;
        else value = {$urandom} & 32'hFFFF_0000 | 32'($urandom_range(0, 12));
        write_reg(RegDebounce, value);
      end
      if ($urandom_range(0, 9) < 5) write_reg(RegPpr, $urandom);
      src_gaps  = $urandom_range(0, 2) != 0;
      snk_gaps  = $urandom_range(0, 2) != 0;
      periodic  = $urandom_range(0, 1);
      case ($urandom_range(0, 3))
        0:       density = 0;
        1:       density = 1;
        2:       density = 3;
        default: density = 15;
      endcase
      // edge spacing around the debounce boundary for a debounce of 40 or less
      period    = (deb_cfg > 16'd40) ? $urandom_range(1, 8)
                                     : int'(deb_cfg) + $urandom_range(0, 3);
      if (period == 0) period = 1;
      countdown = period;
      n_ticks   = $urandom_range(16, 100);
      for (k = 0; k < n_ticks; k++) begin
        if (periodic) begin
          countdown--;
          edge_bit = (countdown == 0);
          if (countdown == 0) countdown = period;
        end else begin
          edge_bit = ($urandom_range(0, density) == 0);
        end
        send_tick(edge_bit, 1'b0, '0);
        random_ticks++;
      end
    end

    // drain and report
    @(negedge clk_i);
    tick_valid <= 1'b0;
    while (windows_due.size() != 0) @(posedge clk_i);
    repeat (END_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** debounced_rpm_meter_moving_average: PASSED **");
    end else begin
      $display("** debounced_rpm_meter_moving_average: FAILED **");
    end
    $finish;
  end

endmodule

>>> debounced_rpm_meter_moving_average.f
rtl/drm_pkg.sv
rtl/drm_front.sv
rtl/drm_queue.sv
rtl/drm_div.sv
rtl/drm_back.sv
rtl/debounced_rpm_meter_moving_average.sv
rtl/drm_checker.sv
verif/tb_debounced_rpm_meter_moving_average.sv
